/* sv/bfpa_pkg.sv */
// bfpa_pkg: shared types, constants and command codes of the best-fit page allocator.
// No dependencies; imported by every other file of the block.
package bfpa_pkg;

    localparam int HEAP_PAGES_DEF = 64;
    localparam int PAGE_BYTES     = 4096;
    localparam int HEADER_BYTES   = 24;
    localparam int LOG2_PAGE      = $clog2(PAGE_BYTES);
    localparam int ADDR_W         = 18;
    localparam int LIMIT_W        = 7;
    localparam int LIMIT_RESET    = 64;
    // request + header fits in 20 bits; page count after rounding
    localparam int TOTAL_W        = 20;
    localparam int PG_W           = TOTAL_W - LOG2_PAGE;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_BADFREE = 2'd2;

    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE  = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 4'd1;
    localparam logic [OP_W-1:0] OP_SCAN  = 4'd2;
    localparam logic [OP_W-1:0] OP_A1    = 4'd3;
    localparam logic [OP_W-1:0] OP_A2    = 4'd4;
    localparam logic [OP_W-1:0] OP_FCHK  = 4'd5;
    localparam logic [OP_W-1:0] OP_FNXT  = 4'd6;
    localparam logic [OP_W-1:0] OP_FMRG  = 4'd7;
    localparam logic [OP_W-1:0] OP_FPREV = 4'd8;
    localparam logic [OP_W-1:0] OP_FPM   = 4'd9;
    localparam logic [OP_W-1:0] OP_FTRIM = 4'd10;
    localparam logic [OP_W-1:0] OP_PUSH  = 4'd11;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] request_bytes;
        logic [ADDR_W-1:0] block_address;
    } in_word_t;

    typedef struct packed {
        logic [ADDR_W-1:0] granted_address;
        logic [1:0]        status;
    } out_word_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } cmd_t;

    typedef struct packed {
        logic in_kind;
        logic scan_done;
        logic free_ok;
        logic prev_hit;
        logic prev_none;
    } sts_t;

endpackage

/* sv/bfpa_ctrl.sv */
// bfpa_ctrl: allocator sequencer; at most one datapath command per cycle.
// Depends on bfpa_pkg.
module bfpa_ctrl
    import bfpa_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_A1    = 4'd2;
    localparam logic [3:0] S_A2    = 4'd3;
    localparam logic [3:0] S_FCHK  = 4'd4;
    localparam logic [3:0] S_FNXT  = 4'd5;
    localparam logic [3:0] S_FMRG  = 4'd6;
    localparam logic [3:0] S_FPREV = 4'd7;
    localparam logic [3:0] S_FPM   = 4'd8;
    localparam logic [3:0] S_FTRIM = 4'd9;
    localparam logic [3:0] S_PUSH  = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd.op       = OP_NONE;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = (sts.in_kind == KIND_FREE) ? S_FCHK : S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.op = OP_SCAN;
                if (sts.scan_done) state_next = S_A1;
            end
            S_A1: begin
                cmd.op     = OP_A1;
                state_next = S_A2;
            end
            S_A2: begin
                cmd.op     = OP_A2;
                state_next = S_PUSH;
            end
            S_FCHK: begin
                cmd.op     = OP_FCHK;
                state_next = sts.free_ok ? S_FNXT : S_PUSH;
            end
            S_FNXT: begin
                cmd.op     = OP_FNXT;
                state_next = S_FMRG;
            end
            S_FMRG: begin
                cmd.op     = OP_FMRG;
                state_next = S_FPREV;
            end
            S_FPREV: begin
                cmd.op = OP_FPREV;
                if (sts.prev_hit)       state_next = S_FPM;
                else if (sts.prev_none) state_next = S_FTRIM;
            end
            S_FPM: begin
                cmd.op     = OP_FPM;
                state_next = S_FTRIM;
            end
            S_FTRIM: begin
                cmd.op     = OP_FTRIM;
                state_next = S_PUSH;
            end
            S_PUSH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.op       = OP_PUSH;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

/* sv/bfpa_datapath.sv */
// bfpa_datapath: chunk maps, chunk length memory, scan and merge registers.
// Depends on bfpa_pkg; driven by bfpa_ctrl commands.
module bfpa_datapath
    import bfpa_pkg::*;
#(
    parameter int HEAP_PAGES = HEAP_PAGES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  in_word_t           s_word,
    input  logic [LIMIT_W-1:0] heap_limit,
    input  cmd_t               cmd,
    output sts_t               sts,
    output out_word_t          m_word
);

    localparam int AW = $clog2(HEAP_PAGES);
    localparam int LW = $clog2(HEAP_PAGES + 1);

    logic [HEAP_PAGES-1:0] start_reg, busy_reg;
    logic [LW-1:0]         end_reg;

    logic [LW-1:0] len_mem [HEAP_PAGES];
    logic [LW-1:0] rd_data_reg;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [LW-1:0] wr_data;
    logic          wr_en;

    logic [PG_W-1:0]   pages_reg;
    logic [AW-1:0]     cur_reg, nxt_reg, q_reg, best_reg, pend_page_reg;
    logic [LW-1:0]     lcur_reg, best_len_reg, scan_p_reg;
    logic [LW:0]       next_start_reg;
    logic              free_ok_reg, merge_reg, pq_free_reg, found_reg, pend_reg;
    logic [ADDR_W-1:0] res_addr_reg;
    logic [1:0]        res_status_reg;
    out_word_t         out_word_reg;

    logic [LW-1:0]     rd_len;
    logic              issue, eval, take, merge_c, grow_ok, trim, split_en;
    logic [LW:0]       nxt_sum;
    logic [AW-1:0]     q_dec, split_addr;
    logic [31:0]       lim;
    logic [TOTAL_W-1:0] total, pages_w;
    logic [ADDR_W-1:0] off, pg;
    logic [AW-1:0]     ld_cur;
    logic              ld_ok;

    function automatic logic [ADDR_W-1:0] addr_of(input logic [AW-1:0] page);
        return ADDR_W'((32'(page) << LOG2_PAGE) + 32'(HEADER_BYTES));
    endfunction

    // a stored length of zero counts as one page
    assign rd_len   = (rd_data_reg == '0) ? LW'(1) : rd_data_reg;
    assign issue    = 32'(scan_p_reg) < 32'(end_reg);
    assign eval     = pend_reg && (32'(pend_page_reg) == 32'(next_start_reg));
    assign take     = eval && !busy_reg[pend_page_reg]
                      && (32'(rd_len) >= 32'(pages_reg))
                      && (!found_reg || rd_len < best_len_reg);
    assign nxt_sum  = (LW+1)'(cur_reg) + (LW+1)'(rd_len);
    assign merge_c  = (32'(nxt_sum) < 32'(end_reg)) && !busy_reg[nxt_sum[AW-1:0]];
    assign q_dec    = q_reg - AW'(1);
    assign lim      = (32'(heap_limit) > HEAP_PAGES) ? 32'(HEAP_PAGES) : 32'(heap_limit);
    assign grow_ok  = (32'(end_reg) < lim) && (32'(pages_reg) <= lim - 32'(end_reg));
    assign split_en = found_reg && (32'(best_len_reg) > 32'(pages_reg));
    assign split_addr = AW'(32'(best_reg) + 32'(pages_reg));
    assign trim     = (32'(cur_reg) + 32'(lcur_reg)) >= 32'(end_reg);

    // item capture: page count and free address checks
    assign total   = TOTAL_W'(s_word.request_bytes) + TOTAL_W'(HEADER_BYTES);
    assign pages_w = (total + TOTAL_W'(PAGE_BYTES - 1)) >> LOG2_PAGE;
    assign off     = s_word.block_address - ADDR_W'(HEADER_BYTES);
    assign pg      = off >> LOG2_PAGE;
    assign ld_cur  = pg[AW-1:0];
    assign ld_ok   = (32'(s_word.block_address) >= 32'(HEADER_BYTES))
                     && (off[LOG2_PAGE-1:0] == '0)
                     && (32'(pg) < 32'(end_reg))
                     && start_reg[ld_cur] && busy_reg[ld_cur];

    always_comb begin
        unique case (cmd.op)
            OP_SCAN:  rd_addr = scan_p_reg[AW-1:0];
            OP_FNXT:  rd_addr = nxt_sum[AW-1:0];
            OP_FPREV: rd_addr = q_dec;
            default:  rd_addr = cur_reg;
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = cur_reg;
        wr_data = lcur_reg;
        unique case (cmd.op)
            OP_A1: begin
                wr_en   = split_en;
                wr_addr = split_addr;
                wr_data = best_len_reg - LW'(pages_reg);
            end
            OP_A2: begin
                wr_en   = found_reg || grow_ok;
                wr_addr = found_reg ? best_reg : end_reg[AW-1:0];
                wr_data = LW'(pages_reg);
            end
            OP_FMRG: begin
                wr_en   = merge_reg;
                wr_data = lcur_reg + rd_len;
            end
            OP_FPM: begin
                wr_en   = pq_free_reg;
                wr_addr = q_reg;
                wr_data = rd_len + lcur_reg;
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) len_mem[wr_addr] <= wr_data;
        rd_data_reg <= len_mem[rd_addr];
    end

    // chunk maps and heap end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= '0;
            busy_reg  <= '0;
            end_reg   <= '0;
        end else begin
            case (cmd.op)
                OP_A1: begin
                    if (split_en) begin
                        start_reg[split_addr] <= 1'b1;
                        busy_reg[split_addr]  <= 1'b0;
                    end
                end
                OP_A2: begin
                    if (found_reg) begin
                        busy_reg[best_reg] <= 1'b1;
                    end else if (grow_ok) begin
                        start_reg[end_reg[AW-1:0]] <= 1'b1;
                        busy_reg[end_reg[AW-1:0]]  <= 1'b1;
                        end_reg <= end_reg + LW'(pages_reg);
                    end
                end
                OP_FCHK:  if (free_ok_reg) busy_reg[cur_reg] <= 1'b0;
                OP_FMRG:  if (merge_reg) start_reg[nxt_reg] <= 1'b0;
                OP_FPM:   if (pq_free_reg) start_reg[cur_reg] <= 1'b0;
                OP_FTRIM: begin
                    if (trim) begin
                        start_reg[cur_reg] <= 1'b0;
                        end_reg <= LW'(cur_reg);
                    end
                end
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                pages_reg      <= pages_w[PG_W-1:0];
                cur_reg        <= ld_cur;
                free_ok_reg    <= ld_ok;
                scan_p_reg     <= '0;
                pend_reg       <= 1'b0;
                next_start_reg <= '0;
                found_reg      <= 1'b0;
            end
            OP_SCAN: begin
                if (issue) scan_p_reg <= scan_p_reg + LW'(1);
                pend_reg      <= issue;
                pend_page_reg <= scan_p_reg[AW-1:0];
                if (eval) next_start_reg <= (LW+1)'(pend_page_reg) + (LW+1)'(rd_len);
                if (take) begin
                    found_reg    <= 1'b1;
                    best_reg     <= pend_page_reg;
                    best_len_reg <= rd_len;
                end
            end
            OP_A2: begin
                if (found_reg) begin
                    res_addr_reg   <= addr_of(best_reg);
                    res_status_reg <= ST_DONE;
                end else if (grow_ok) begin
                    res_addr_reg   <= addr_of(end_reg[AW-1:0]);
                    res_status_reg <= ST_DONE;
                end else begin
                    res_addr_reg   <= '0;
                    res_status_reg <= ST_NOSPACE;
                end
            end
            OP_FCHK: begin
                res_addr_reg   <= '0;
                res_status_reg <= ST_BADFREE;
            end
            OP_FNXT: begin
                lcur_reg  <= rd_len;
                nxt_reg   <= nxt_sum[AW-1:0];
                merge_reg <= merge_c;
            end
            OP_FMRG: begin
                if (merge_reg) lcur_reg <= lcur_reg + rd_len;
                q_reg <= cur_reg;
            end
            OP_FPREV: begin
                if (q_reg != '0) begin
                    q_reg       <= q_dec;
                    pq_free_reg <= !busy_reg[q_dec];
                end
            end
            OP_FPM: begin
                if (pq_free_reg) begin
                    cur_reg  <= q_reg;
                    lcur_reg <= rd_len + lcur_reg;
                end
            end
            OP_FTRIM: begin
                res_addr_reg   <= '0;
                res_status_reg <= ST_DONE;
            end
            OP_PUSH: begin
                out_word_reg.granted_address <= res_addr_reg;
                out_word_reg.status          <= res_status_reg;
            end
            default: ;
        endcase
    end

    assign sts.in_kind   = s_word.kind;
    assign sts.scan_done = !issue && !pend_reg;
    assign sts.free_ok   = free_ok_reg;
    assign sts.prev_hit  = (q_reg != '0) && start_reg[q_dec];
    assign sts.prev_none = (q_reg == '0);
    assign m_word        = out_word_reg;

endmodule

/* sv/best_fit_page_allocator.sv */
// best_fit_page_allocator: top level; APB limit register, sequencer and datapath.
// Depends on bfpa_pkg, bfpa_ctrl, bfpa_datapath.
//
//  channel | ports                         | word
//  --------+-------------------------------+-------------------------------
//  input   | s_valid s_ready s_word        | kind, request_bytes, block_address
//  result  | m_valid m_ready m_word        | granted_address, status
//  config  | psel penable pwrite paddr ... | heap_limit_pages at 0x0
//
// Allocate: the word is captured, then the chunk length memory is scanned, one
//   page entry a cycle over the heap, then a split write and a grant write, and
//   a hand-over step that waits until the old result has left.
// Free: a rejected word is only captured, checked and handed over; a valid
//   one also reads/merges with the next chunk, then walks down the start map,
//   one page a cycle, to find the previous chunk, then may merge and trim.
// The length store has one read port and one write port.
// Reset clears the maps and heap end at once; the length store needs no sweep.
// A new word is taken while a finished result still waits; the result register
//   is loaded only once the old word has left.
module best_fit_page_allocator
    import bfpa_pkg::*;
#(
    parameter int HEAP_PAGES = HEAP_PAGES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_word_t    s_word,
    output logic        m_valid,
    input  logic        m_ready,
    output out_word_t   m_word,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [LIMIT_W-1:0] limit_reg;
    cmd_t cmd;
    sts_t sts;

    // single register; every word address decodes to it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_W'(LIMIT_RESET);
        end else if (psel && penable && pwrite) begin
            limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[1:0] == 2'd0) ? 32'(limit_reg) : 32'(limit_reg);

    bfpa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bfpa_datapath #(.HEAP_PAGES(HEAP_PAGES)) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_word     (s_word),
        .heap_limit (limit_reg),
        .cmd        (cmd),
        .sts        (sts),
        .m_word     (m_word)
    );

endmodule

/* sv/bfpa_checker.sv */
// bfpa_checker: port-level assertions for best_fit_page_allocator, with its bind.
// Depends on bfpa_pkg.
module bfpa_checker
    import bfpa_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_word
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word))
        else $error("result word changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word.status != ST_DONE |-> m_word.granted_address == '0
            && (m_word.status == ST_NOSPACE || m_word.status == ST_BADFREE))
        else $error("failed result with address or bad status");

    a_grant_hdr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word.status == ST_DONE && m_word.granted_address != '0
        |-> m_word.granted_address[LOG2_PAGE-1:0] == LOG2_PAGE'(HEADER_BYTES))
        else $error("granted address not header past a page");

endmodule

bind best_fit_page_allocator bfpa_checker u_bfpa_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_word  (m_word)
);
